>>> rtl/core/ffha_pkg.sv
// Package: shared types, constants and helpers of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

   localparam int HEAP_BYTES_DEF = 65536;
   localparam logic [31:0] MIN_BLOCK = 32'd24;
   localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFF8;
   localparam logic [31:0] FIRST_BP = 32'd48;
   localparam logic [31:0] HEAD_RESET = 32'd48;
   localparam logic [31:0] BRK_RESET = 32'd304;
   localparam logic [16:0] CHUNK_RESET = 17'd256;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef enum logic [1:0] {
      CMD_MALLOC  = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_REALLOC = 2'd2
   } cmd_type;

   typedef enum logic [5:0] {
      S_CLR, S_IDLE, S_DISP, S_VAL, S_VAL2,
      S_FR_R, S_FR_T1, S_FR_T2,
      S_MG_R0, S_MG_R1, S_MG_R2, S_MG_R3, S_MG_R4, S_MG_UN2, S_MG_TAG, S_MG_TAG2,
      S_PUSH0, S_PUSH1, S_PUSH2,
      S_UN_R0, S_UN_R1, S_UN_W, S_UN_W2,
      S_MA_START, S_SR_CHK, S_SR_H, S_SR_N,
      S_GR0, S_GR1, S_GR2, S_GR_RET,
      S_TK_R, S_TK_C, S_TK_S1, S_TK_S2, S_TK_S3, S_TK_N1, S_MA_END, S_DONE_M,
      S_RA0, S_RA1, S_RA_S1, S_RA_S2, S_RA_AFTER, S_CP_CHK, S_CP_WR,
      S_OUT
   } state_type;

   typedef struct packed {
      logic        re;
      logic        we;
      logic [31:0] addr;
      logic [31:0] wdata;
   } mem_req_type;

   // padded payload size, at least one minimum block
   function automatic logic [31:0] adjusted(input logic [15:0] size);
      logic [31:0] a;
      a = ((32'(size) + 32'd7) & SIZE_MASK) + 32'd8;
      return (a < MIN_BLOCK) ? MIN_BLOCK : a;
   endfunction

   // heap image after reset: prologue, end marks, one 256-byte free block at 48
   function automatic logic [31:0] init_word(input logic [31:0] idx);
      logic [31:0] v;
      unique case (idx)
         32'd1:   v = 32'd25;
         32'd2:   v = 32'd48;
         32'd6:   v = 32'd25;
         32'd7:   v = 32'd1;
         32'd11:  v = 32'd256;
         32'd14:  v = 32'd8;
         32'd74:  v = 32'd256;
         32'd75:  v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/core/ffha_if.sv
// Interfaces: request and response channels of the allocator.
`timescale 1ns / 1ps

interface ffha_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] request_size;
   logic [15:0] block_address;
   modport source (output valid, command, request_size, block_address, input ready);
   modport sink (input valid, command, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_address;
   logic [1:0]  status;
   modport source (output valid, result_address, status, input ready);
   modport sink (input valid, result_address, status, output ready);
endinterface

>>> rtl/core/ffha_heap_mem.sv
// Heap word memory: one port, registered read, out-of-range reads give 0.
`timescale 1ns / 1ps

module ffha_heap_mem #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
   input  logic                 clock,
   input  ffha_pkg::mem_req_type mem_req,
   output logic [31:0]          mem_rdata
);
   localparam int WORDS = HEAP_BYTES / 4;
   localparam int IW = $clog2(WORDS);

   logic [31:0] mem [WORDS];
   logic [31:0] q_ff;
   logic        oob_ff;
   logic        oob;
   logic [IW-1:0] idx;

   assign oob = mem_req.addr[31:2] >= 30'(WORDS);
   assign idx = mem_req.addr[IW+1:2];

   always_ff @(posedge clock) begin
      if (mem_req.we && !oob) begin
         mem[idx] <= mem_req.wdata;
      end
      if (mem_req.re && !oob) begin
         q_ff <= mem[idx];
      end
      oob_ff <= oob;
   end

   assign mem_rdata = oob_ff ? 32'd0 : q_ff;
endmodule

>>> rtl/core/ffha_seq.sv
// Allocator sequencer: command decode, list walk, split, merge, copy.
`timescale 1ns / 1ps

module ffha_seq #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ffha_req_if.sink              req,
   input  logic [16:0]           chunk,
   input  logic                  out_ready,
   output logic                  done,
   output logic [15:0]           res,
   output logic [1:0]            st,
   output ffha_pkg::mem_req_type mem_req,
   input  logic [31:0]           mem_rdata
);
   localparam int WORDS = HEAP_BYTES / 4;
   localparam int IW = $clog2(WORDS);
   localparam int LIMIT = HEAP_BYTES / 24 + 2;
   localparam int CNT_W = $clog2(LIMIT + 1);

   ffha_pkg::state_type state_ff, state_in;
   ffha_pkg::state_type merge_ret_ff, merge_ret_in;
   ffha_pkg::state_type un_ret_ff, un_ret_in;
   ffha_pkg::state_type mal_ret_ff, mal_ret_in;
   ffha_pkg::cmd_type   cmd_ff, cmd_in;

   logic [IW-1:0]    clr_ff, clr_in;
   logic [15:0]      size_ff, size_in;
   logic [31:0]      bp_ff, bp_in, old_ff, old_in, asize_ff, asize_in;
   logic [31:0]      mres_ff, mres_in, res_ff, res_in;
   logic [1:0]       st_ff, st_in;
   logic [31:0]      head_ff, head_in, brk_ff, brk_in;
   logic [31:0]      mbp_ff, mbp_in, msize_ff, msize_in, pf_ff, pf_in;
   logic [31:0]      nhdr_ff, nhdr_in, nxt_ff, nxt_in;
   logic [31:0]      ux_ff, ux_in, up_ff, up_in, un_ff, un_in;
   logic [31:0]      sbp_ff, sbp_in, tbp_ff, tbp_in, csize_ff, csize_in;
   logic [31:0]      gsize_ff, gsize_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [14:0]      cw_ff, cw_in, cn_ff, cn_in;

   logic [31:0] rd_sz, pf_sz, gbytes, gwords, gs;
   logic [15:0] cp_n;
   logic        pa, size0, bp0, val_bad, hdr_bad, free_path, split, oom;

   assign rd_sz = mem_rdata & ffha_pkg::SIZE_MASK;
   assign pf_sz = pf_ff & ffha_pkg::SIZE_MASK;
   assign pa = pf_ff[0] || (pf_sz == 32'd0);
   assign size0 = (size_ff == 16'd0);
   assign bp0 = (bp_ff == 32'd0);
   assign val_bad = (bp_ff[2:0] != 3'd0) || (bp_ff < ffha_pkg::FIRST_BP) || (bp_ff >= brk_ff);
   assign hdr_bad = !mem_rdata[0] || (rd_sz < ffha_pkg::MIN_BLOCK) ||
                    ({1'b0, bp_ff} + {1'b0, rd_sz} > {1'b0, brk_ff});
   assign free_path = (cmd_ff == ffha_pkg::CMD_FREE) || size0;
   assign split = (rd_sz >= asize_ff) && (rd_sz - asize_ff >= ffha_pkg::MIN_BLOCK);
   // growth: words of max(asize, chunk), even count, at least one minimum block
   assign gbytes = (asize_ff > 32'(chunk)) ? asize_ff : 32'(chunk);
   assign gwords = gbytes >> 2;
   always_comb begin
      gs = (gwords + {31'd0, gwords[0]}) << 2;
      if (gs < ffha_pkg::MIN_BLOCK) gs = ffha_pkg::MIN_BLOCK;
   end
   assign oom = ({1'b0, brk_ff} + {1'b0, gs}) > 33'(HEAP_BYTES);
   assign cp_n = ((old_ff - 32'd8) < 32'(size_ff)) ? 16'(old_ff - 32'd8) : size_ff;

   assign req.ready = (state_ff == ffha_pkg::S_IDLE);
   assign done = (state_ff == ffha_pkg::S_OUT) && out_ready;
   assign res = res_ff[15:0];
   assign st = st_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::S_CLR:   if (clr_ff == IW'(WORDS - 1)) state_in = ffha_pkg::S_IDLE;
         ffha_pkg::S_IDLE:  if (req.valid) state_in = ffha_pkg::S_DISP;
         ffha_pkg::S_DISP: begin
            unique case (cmd_ff)
               ffha_pkg::CMD_MALLOC: state_in = size0 ? ffha_pkg::S_OUT : ffha_pkg::S_MA_START;
               ffha_pkg::CMD_FREE:   state_in = bp0 ? ffha_pkg::S_OUT : ffha_pkg::S_VAL;
               ffha_pkg::CMD_REALLOC: begin
                  if (size0) state_in = bp0 ? ffha_pkg::S_OUT : ffha_pkg::S_VAL;
                  else state_in = bp0 ? ffha_pkg::S_MA_START : ffha_pkg::S_VAL;
               end
               default: state_in = ffha_pkg::S_OUT;
            endcase
         end
         ffha_pkg::S_VAL:   state_in = val_bad ? ffha_pkg::S_OUT : ffha_pkg::S_VAL2;
         ffha_pkg::S_VAL2: begin
            if (hdr_bad) state_in = ffha_pkg::S_OUT;
            else state_in = free_path ? ffha_pkg::S_FR_R : ffha_pkg::S_RA0;
         end
         ffha_pkg::S_FR_R:   state_in = ffha_pkg::S_FR_T1;
         ffha_pkg::S_FR_T1:  state_in = ffha_pkg::S_FR_T2;
         ffha_pkg::S_FR_T2:  state_in = ffha_pkg::S_MG_R0;
         ffha_pkg::S_MG_R0:  state_in = ffha_pkg::S_MG_R1;
         ffha_pkg::S_MG_R1:  state_in = ffha_pkg::S_MG_R2;
         ffha_pkg::S_MG_R2:  state_in = ffha_pkg::S_MG_R3;
         ffha_pkg::S_MG_R3: begin
            if (!pa) state_in = ffha_pkg::S_MG_R4;
            else state_in = mem_rdata[0] ? ffha_pkg::S_PUSH0 : ffha_pkg::S_UN_R0;
         end
         ffha_pkg::S_MG_R4:   state_in = ffha_pkg::S_UN_R0;
         ffha_pkg::S_MG_UN2:  state_in = ffha_pkg::S_UN_R0;
         ffha_pkg::S_MG_TAG:  state_in = ffha_pkg::S_MG_TAG2;
         ffha_pkg::S_MG_TAG2: state_in = ffha_pkg::S_PUSH0;
         ffha_pkg::S_PUSH0:   state_in = ffha_pkg::S_PUSH1;
         ffha_pkg::S_PUSH1:   state_in = ffha_pkg::S_PUSH2;
         ffha_pkg::S_PUSH2:   state_in = merge_ret_ff;
         ffha_pkg::S_UN_R0:   state_in = ffha_pkg::S_UN_R1;
         ffha_pkg::S_UN_R1:   state_in = ffha_pkg::S_UN_W;
         ffha_pkg::S_UN_W:    state_in = ffha_pkg::S_UN_W2;
         ffha_pkg::S_UN_W2:   state_in = un_ret_ff;
         ffha_pkg::S_MA_START: state_in = ffha_pkg::S_SR_CHK;
         ffha_pkg::S_SR_CHK:
            state_in = (cnt_ff == CNT_W'(LIMIT)) ? ffha_pkg::S_GR0 : ffha_pkg::S_SR_H;
         ffha_pkg::S_SR_H: begin
            if (mem_rdata[0]) state_in = ffha_pkg::S_GR0;
            else if (asize_ff <= rd_sz) state_in = ffha_pkg::S_TK_R;
            else state_in = ffha_pkg::S_SR_N;
         end
         ffha_pkg::S_SR_N:   state_in = ffha_pkg::S_SR_CHK;
         ffha_pkg::S_GR0:    state_in = oom ? ffha_pkg::S_MA_END : ffha_pkg::S_GR1;
         ffha_pkg::S_GR1:    state_in = ffha_pkg::S_GR2;
         ffha_pkg::S_GR2:    state_in = ffha_pkg::S_MG_R0;
         ffha_pkg::S_GR_RET: state_in = ffha_pkg::S_TK_R;
         ffha_pkg::S_TK_R:   state_in = ffha_pkg::S_TK_C;
         ffha_pkg::S_TK_C:   state_in = split ? ffha_pkg::S_TK_S1 : ffha_pkg::S_TK_N1;
         ffha_pkg::S_TK_S1:  state_in = ffha_pkg::S_UN_R0;
         ffha_pkg::S_TK_S2:  state_in = ffha_pkg::S_TK_S3;
         ffha_pkg::S_TK_S3:  state_in = ffha_pkg::S_MG_R0;
         ffha_pkg::S_TK_N1:  state_in = ffha_pkg::S_UN_R0;
         ffha_pkg::S_MA_END: state_in = mal_ret_ff;
         ffha_pkg::S_DONE_M: state_in = ffha_pkg::S_OUT;
         ffha_pkg::S_RA0:    state_in = ffha_pkg::S_RA1;
         ffha_pkg::S_RA1: begin
            if (asize_ff == old_ff) state_in = ffha_pkg::S_OUT;
            else if (asize_ff < old_ff)
               state_in = (old_ff - asize_ff >= ffha_pkg::MIN_BLOCK) ?
                          ffha_pkg::S_RA_S1 : ffha_pkg::S_OUT;
            else state_in = ffha_pkg::S_MA_START;
         end
         ffha_pkg::S_RA_S1:  state_in = ffha_pkg::S_RA_S2;
         ffha_pkg::S_RA_S2:  state_in = ffha_pkg::S_FR_R;
         ffha_pkg::S_RA_AFTER:
            state_in = (mres_ff == 32'd0) ? ffha_pkg::S_OUT : ffha_pkg::S_CP_CHK;
         ffha_pkg::S_CP_CHK: state_in = (cw_ff == cn_ff) ? ffha_pkg::S_FR_R : ffha_pkg::S_CP_WR;
         ffha_pkg::S_CP_WR:  state_in = ffha_pkg::S_CP_CHK;
         ffha_pkg::S_OUT:    if (out_ready) state_in = ffha_pkg::S_IDLE;
         default:            state_in = ffha_pkg::S_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      mem_req = '0;
      merge_ret_in = merge_ret_ff;  un_ret_in = un_ret_ff;  mal_ret_in = mal_ret_ff;
      cmd_in = cmd_ff;  clr_in = clr_ff;  size_in = size_ff;  bp_in = bp_ff;
      old_in = old_ff;  asize_in = asize_ff;  mres_in = mres_ff;  res_in = res_ff;
      st_in = st_ff;  head_in = head_ff;  brk_in = brk_ff;  mbp_in = mbp_ff;
      msize_in = msize_ff;  pf_in = pf_ff;  nhdr_in = nhdr_ff;  nxt_in = nxt_ff;
      ux_in = ux_ff;  up_in = up_ff;  un_in = un_ff;  sbp_in = sbp_ff;  tbp_in = tbp_ff;
      csize_in = csize_ff;  gsize_in = gsize_ff;  cnt_in = cnt_ff;  cw_in = cw_ff;
      cn_in = cn_ff;
      unique case (state_ff)
         ffha_pkg::S_CLR: begin
            mem_req.we = 1'b1;
            mem_req.addr = 32'(clr_ff) << 2;
            mem_req.wdata = ffha_pkg::init_word(32'(clr_ff));
            clr_in = clr_ff + 1'b1;
         end
         ffha_pkg::S_IDLE: begin
            cmd_in = ffha_pkg::cmd_type'(req.command);
            size_in = req.request_size;
            bp_in = 32'(req.block_address);
         end
         ffha_pkg::S_DISP: begin
            res_in = 32'd0;
            st_in = (size0 && (cmd_ff == ffha_pkg::CMD_MALLOC || cmd_ff == ffha_pkg::CMD_REALLOC))
                    ? ffha_pkg::ST_ZERO : ffha_pkg::ST_OK;
            mal_ret_in = ffha_pkg::S_DONE_M;
         end
         ffha_pkg::S_VAL: begin
            mem_req.re = !val_bad;
            mem_req.addr = bp_ff - 32'd4;
         end
         ffha_pkg::S_VAL2: begin
            old_in = rd_sz;
            mbp_in = bp_ff;
            merge_ret_in = ffha_pkg::S_OUT;
         end
         ffha_pkg::S_FR_R: begin
            mem_req.re = 1'b1;
            mem_req.addr = mbp_ff - 32'd4;
         end
         ffha_pkg::S_FR_T1: begin
            msize_in = rd_sz;
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff - 32'd4;
            mem_req.wdata = rd_sz;
         end
         ffha_pkg::S_FR_T2, ffha_pkg::S_MG_TAG2: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff + msize_ff - 32'd8;
            mem_req.wdata = msize_ff;
         end
         ffha_pkg::S_MG_R0: begin
            mem_req.re = 1'b1;
            mem_req.addr = mbp_ff - 32'd8;
         end
         ffha_pkg::S_MG_R1: begin
            pf_in = mem_rdata;
            mem_req.re = 1'b1;
            mem_req.addr = mbp_ff - 32'd4;
         end
         ffha_pkg::S_MG_R2: begin
            msize_in = rd_sz;
            nxt_in = mbp_ff + rd_sz;
            mem_req.re = 1'b1;
            mem_req.addr = mbp_ff + rd_sz - 32'd4;
         end
         ffha_pkg::S_MG_R3: begin
            nhdr_in = mem_rdata;
            if (!pa) begin
               mem_req.re = 1'b1;
               mem_req.addr = mbp_ff - pf_sz - 32'd4;
            end else if (!mem_rdata[0]) begin
               // only the next block is free
               msize_in = msize_ff + rd_sz;
               ux_in = nxt_ff;
               un_ret_in = ffha_pkg::S_MG_TAG;
            end
         end
         ffha_pkg::S_MG_R4: begin
            mbp_in = mbp_ff - pf_sz;
            ux_in = mbp_ff - pf_sz;
            if (nhdr_ff[0]) begin
               msize_in = msize_ff + rd_sz;
               un_ret_in = ffha_pkg::S_MG_TAG;
            end else begin
               msize_in = msize_ff + rd_sz + (nhdr_ff & ffha_pkg::SIZE_MASK);
               un_ret_in = ffha_pkg::S_MG_UN2;
            end
         end
         ffha_pkg::S_MG_UN2: begin
            ux_in = nxt_ff;
            un_ret_in = ffha_pkg::S_MG_TAG;
         end
         ffha_pkg::S_MG_TAG: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff - 32'd4;
            mem_req.wdata = msize_ff;
         end
         ffha_pkg::S_PUSH0: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff + 32'd8;
            mem_req.wdata = head_ff;
         end
         ffha_pkg::S_PUSH1: begin
            mem_req.we = 1'b1;
            mem_req.addr = head_ff;
            mem_req.wdata = mbp_ff;
         end
         ffha_pkg::S_PUSH2: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff;
            mem_req.wdata = 32'd0;
            head_in = mbp_ff;
         end
         ffha_pkg::S_UN_R0: begin
            mem_req.re = 1'b1;
            mem_req.addr = ux_ff;
         end
         ffha_pkg::S_UN_R1: begin
            up_in = mem_rdata;
            mem_req.re = 1'b1;
            mem_req.addr = ux_ff + 32'd8;
         end
         ffha_pkg::S_UN_W: begin
            un_in = mem_rdata;
            if (up_ff != 32'd0) begin
               mem_req.we = 1'b1;
               mem_req.addr = up_ff + 32'd8;
               mem_req.wdata = mem_rdata;
            end else begin
               head_in = mem_rdata;
            end
         end
         ffha_pkg::S_UN_W2: begin
            mem_req.we = 1'b1;
            mem_req.addr = un_ff;
            mem_req.wdata = up_ff;
         end
         ffha_pkg::S_MA_START: begin
            asize_in = ffha_pkg::adjusted(size_ff);
            sbp_in = head_ff;
            cnt_in = '0;
         end
         ffha_pkg::S_SR_CHK: begin
            mem_req.re = (cnt_ff != CNT_W'(LIMIT));
            mem_req.addr = sbp_ff - 32'd4;
         end
         ffha_pkg::S_SR_H: begin
            tbp_in = sbp_ff;
            mem_req.re = !mem_rdata[0] && (asize_ff > rd_sz);
            mem_req.addr = sbp_ff + 32'd8;
         end
         ffha_pkg::S_SR_N: begin
            sbp_in = mem_rdata;
            cnt_in = cnt_ff + 1'b1;
         end
         ffha_pkg::S_GR0: begin
            if (oom) begin
               mres_in = 32'd0;
            end else begin
               mem_req.we = 1'b1;
               mem_req.addr = brk_ff - 32'd4;
               mem_req.wdata = gs;
               gsize_in = gs;
               mbp_in = brk_ff;
            end
         end
         ffha_pkg::S_GR1: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff + gsize_ff - 32'd8;
            mem_req.wdata = gsize_ff;
         end
         ffha_pkg::S_GR2: begin
            // new end mark past the grown block
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff + gsize_ff - 32'd4;
            mem_req.wdata = 32'd1;
            brk_in = brk_ff + gsize_ff;
            merge_ret_in = ffha_pkg::S_GR_RET;
         end
         ffha_pkg::S_GR_RET: tbp_in = mbp_ff;
         ffha_pkg::S_TK_R: begin
            mem_req.re = 1'b1;
            mem_req.addr = tbp_ff - 32'd4;
         end
         ffha_pkg::S_TK_C: begin
            csize_in = rd_sz;
            mres_in = tbp_ff;
            mem_req.we = 1'b1;
            mem_req.addr = tbp_ff - 32'd4;
            mem_req.wdata = split ? (asize_ff | 32'd1) : (rd_sz | 32'd1);
         end
         ffha_pkg::S_TK_S1: begin
            mem_req.we = 1'b1;
            mem_req.addr = tbp_ff + asize_ff - 32'd8;
            mem_req.wdata = asize_ff | 32'd1;
            ux_in = tbp_ff;
            un_ret_in = ffha_pkg::S_TK_S2;
         end
         ffha_pkg::S_TK_S2: begin
            mbp_in = tbp_ff + asize_ff;
            mem_req.we = 1'b1;
            mem_req.addr = tbp_ff + asize_ff - 32'd4;
            mem_req.wdata = csize_ff - asize_ff;
         end
         ffha_pkg::S_TK_S3: begin
            mem_req.we = 1'b1;
            mem_req.addr = mbp_ff + (csize_ff - asize_ff) - 32'd8;
            mem_req.wdata = csize_ff - asize_ff;
            merge_ret_in = ffha_pkg::S_MA_END;
         end
         ffha_pkg::S_TK_N1: begin
            mem_req.we = 1'b1;
            mem_req.addr = tbp_ff + csize_ff - 32'd8;
            mem_req.wdata = csize_ff | 32'd1;
            ux_in = tbp_ff;
            un_ret_in = ffha_pkg::S_MA_END;
         end
         ffha_pkg::S_MA_END: ;
         ffha_pkg::S_DONE_M: begin
            res_in = mres_ff;
            st_in = (mres_ff == 32'd0) ? ffha_pkg::ST_OOM : ffha_pkg::ST_OK;
         end
         ffha_pkg::S_RA0: asize_in = ffha_pkg::adjusted(size_ff);
         ffha_pkg::S_RA1: begin
            res_in = bp_ff;
            mal_ret_in = ffha_pkg::S_RA_AFTER;
            if (asize_ff < old_ff && (old_ff - asize_ff >= ffha_pkg::MIN_BLOCK)) begin
               mem_req.we = 1'b1;
               mem_req.addr = bp_ff - 32'd4;
               mem_req.wdata = asize_ff | 32'd1;
            end
         end
         ffha_pkg::S_RA_S1: begin
            mem_req.we = 1'b1;
            mem_req.addr = bp_ff + asize_ff - 32'd8;
            mem_req.wdata = asize_ff | 32'd1;
         end
         ffha_pkg::S_RA_S2: begin
            // the cut-off tail is tagged allocated, then freed
            mem_req.we = 1'b1;
            mem_req.addr = bp_ff + asize_ff - 32'd4;
            mem_req.wdata = (old_ff - asize_ff) | 32'd1;
            mbp_in = bp_ff + asize_ff;
            merge_ret_in = ffha_pkg::S_OUT;
         end
         ffha_pkg::S_RA_AFTER: begin
            if (mres_ff == 32'd0) begin
               res_in = bp_ff;
               st_in = ffha_pkg::ST_OOM;
            end
            cn_in = 15'((17'(cp_n) + 17'd3) >> 2);
            cw_in = '0;
         end
         ffha_pkg::S_CP_CHK: begin
            if (cw_ff == cn_ff) begin
               mbp_in = bp_ff;
               merge_ret_in = ffha_pkg::S_OUT;
               res_in = mres_ff;
            end else begin
               mem_req.re = 1'b1;
               mem_req.addr = bp_ff + (32'(cw_ff) << 2);
            end
         end
         ffha_pkg::S_CP_WR: begin
            mem_req.we = 1'b1;
            mem_req.addr = mres_ff + (32'(cw_ff) << 2);
            mem_req.wdata = mem_rdata;
            cw_in = cw_ff + 1'b1;
         end
         ffha_pkg::S_OUT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_CLR;
         clr_ff <= '0;
         head_ff <= ffha_pkg::HEAD_RESET;
         brk_ff <= ffha_pkg::BRK_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         brk_ff <= brk_in;
      end
   end

   always_ff @(posedge clock) begin
      merge_ret_ff <= merge_ret_in;  un_ret_ff <= un_ret_in;  mal_ret_ff <= mal_ret_in;
      cmd_ff <= cmd_in;  size_ff <= size_in;  bp_ff <= bp_in;  old_ff <= old_in;
      asize_ff <= asize_in;  mres_ff <= mres_in;  res_ff <= res_in;  st_ff <= st_in;
      mbp_ff <= mbp_in;  msize_ff <= msize_in;  pf_ff <= pf_in;  nhdr_ff <= nhdr_in;
      nxt_ff <= nxt_in;  ux_ff <= ux_in;  up_ff <= up_in;  un_ff <= un_in;
      sbp_ff <= sbp_in;  tbp_ff <= tbp_in;  csize_ff <= csize_in;  gsize_ff <= gsize_in;
      cnt_ff <= cnt_in;  cw_ff <= cw_in;  cn_ff <= cn_in;
   end

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffha_pkg::S_CLR |-> !req.ready)
      else $error("request taken during heap clearing");
   a_break_in_heap: assert property (@(posedge clock) disable iff (reset)
      {1'b0, brk_ff} <= 33'(HEAP_BYTES))
      else $error("break beyond heap");
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffha_pkg::S_IDLE |-> !mem_req.we)
      else $error("heap written while idle");
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == ffha_pkg::S_DISP)
      else $error("accepted item not dispatched");
endmodule

>>> rtl/core/first_fit_heap_allocator_unit.sv
// Top level: first-fit heap allocator with explicit free list.
//
//  channel  dir  handshake       payload
//  req_ch   in   valid/ready     command, request_size, block_address
//  rsp_ch   out  valid/ready     result_address, status
//  csr      in   write enable    extend_chunk_bytes (17 bits)
//
// One item at a time. An item needs no heap access when it is a zero-size malloc, a null
// free or an unknown command; otherwise the first-fit walk visits free blocks and a moving
// realloc copies words, and every header, footer and link access goes through the single
// heap memory port.
// After reset a clearing pass writes the heap image, all HEAP_BYTES/4 words (16384 at
// the default), before the first item is taken; csr writes are taken.
// A finished result waits in the output register; the sequencer holds its next result
// until that register drains, so the response side stalls nothing but the next result.
`timescale 1ns / 1ps

module first_fit_heap_allocator_unit #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ffha_req_if.sink    req_ch,
   ffha_rsp_if.source  rsp_ch,
   input  logic        csr_write_enable,
   input  logic [16:0] csr_write_data
);
   ffha_pkg::mem_req_type mem_req;
   logic [31:0] mem_rdata;
   logic [16:0] chunk_ff, chunk_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff, rsp_addr_in;
   logic [1:0]  rsp_st_ff, rsp_st_in;
   logic        out_ready, done;
   logic [15:0] seq_res;
   logic [1:0]  seq_st;

   // output slot can take a new item when empty or draining this cycle
   assign out_ready = !rsp_valid_ff || rsp_ch.ready;

   ffha_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .chunk     (chunk_ff),
      .out_ready (out_ready),
      .done      (done),
      .res       (seq_res),
      .st        (seq_st),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   ffha_heap_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   always_comb begin
      chunk_in = csr_write_enable ? csr_write_data : chunk_ff;
      rsp_valid_in = done ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      rsp_addr_in = done ? seq_res : rsp_addr_ff;
      rsp_st_in = done ? seq_st : rsp_st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= ffha_pkg::CHUNK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         chunk_ff <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_addr_ff <= rsp_addr_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.status = rsp_st_ff;
endmodule
